FILE: rtl/mwir_pkg.sv
// ----------------------------------------------------------------------------
// mwir_pkg
// Shared types and constants of the multi-width integer remainder core.
// ----------------------------------------------------------------------------
`default_nettype none

package mwir_pkg;

  // operand and result width
  localparam int DATA_W  = 64;
  // one restoring step per quotient bit
  localparam int STEPS   = DATA_W;
  // element type register width
  localparam int ETYPE_W = 3;

  // element width code, low two bits of the element type
  typedef enum logic [1:0] {
    WID_8  = 2'd0,
    WID_16 = 2'd1,
    WID_32 = 2'd2,
    WID_64 = 2'd3
  } wid_t;

  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [ETYPE_W-1:0] etype_t;

  // bit of the element type that selects signed elements
  localparam int ETYPE_SIGNED_BIT = 2;

endpackage

`default_nettype wire

FILE: rtl/multi_width_integer_remainder_core.sv
// ----------------------------------------------------------------------------
// multi_width_integer_remainder_core
// Pipelined truncating remainder for u8/u16/u32/u64/i8/i16/i32/i64 elements.
// ----------------------------------------------------------------------------
// The core takes one dividend/divisor transaction per clock while in_ready is
// high and returns one remainder per clock while out_ready is high, in order.
// Each passes an operand stage that extends the operands and takes magnitudes,
// 64 restoring subtract stages (one quotient bit each, the 64-bit compare and
// subtract sets the stage depth), and a stage that restores the sign. The
// remainder carries the sign of the dividend and is sign-extended for signed
// types, zero-extended otherwise. A zero divisor raises divide_by_zero and
// returns the extended dividend. The element type register is written through
// cfg_wr_en/cfg_wr_data and must only change while the core is empty. A skid
// register behind the last stage catches a waiting result so the pipeline can
// keep accepting until it fills; in_ready drops only while the skid register
// is full.
`default_nettype none

module multi_width_integer_remainder_core (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // configuration
  input  wire logic                    cfg_wr_en,
  input  wire mwir_pkg::etype_t        cfg_wr_data,
  // input channel
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire mwir_pkg::data_t         in_dividend,
  input  wire mwir_pkg::data_t         in_divisor,
  // result channel
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output mwir_pkg::data_t              out_remainder,
  output logic                         out_divide_by_zero
);

  import mwir_pkg::*;

  // element type register
  etype_t etype_r;

  // pipeline stage registers: index 0 is the operand stage, index k holds
  // the partial remainder after k restoring steps
  data_t  stg_rem_r [0:STEPS];
  data_t  stg_dvd_r [0:STEPS];
  data_t  stg_dvs_r [0:STEPS];
  logic   stg_neg_r [0:STEPS];
  logic   stg_dz_r  [0:STEPS];
  logic   stg_vld_r [0:STEPS];

  data_t  stg_rem_nxt [1:STEPS];
  data_t  stg_dvd_nxt [1:STEPS];

  // output and skid registers
  data_t  res_r;
  logic   res_dz_r;
  logic   res_vld_r;
  data_t  skid_rem_r;
  logic   skid_dz_r;
  logic   skid_vld_r;
  data_t  res_nxt;

  // operand stage signals
  wid_t   wid;
  logic   sgn;
  data_t  mask;
  logic   a_sign;
  logic   b_sign;
  data_t  a_ext;
  data_t  b_ext;
  logic   a_neg;
  logic   b_neg;
  data_t  a_mag;
  data_t  b_mag;

  logic   adv;

  // pipeline advances whenever the skid register is free
  assign adv      = !skid_vld_r;
  assign in_ready = adv;

  // config write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      etype_r <= '0;
    end else if (cfg_wr_en) begin
      etype_r <= cfg_wr_data;
    end
  end

  // operand extension and magnitudes
  always_comb begin
    wid = wid_t'(etype_r[1:0]);
    sgn = etype_r[ETYPE_SIGNED_BIT];
    case (wid)
      WID_8: begin
        mask   = data_t'(8'hFF);
        a_sign = in_dividend[7];
        b_sign = in_divisor[7];
      end
      WID_16: begin
        mask   = data_t'(16'hFFFF);
        a_sign = in_dividend[15];
        b_sign = in_divisor[15];
      end
      WID_32: begin
        mask   = data_t'(32'hFFFF_FFFF);
        a_sign = in_dividend[31];
        b_sign = in_divisor[31];
      end
      default: begin
        mask   = '1;
        a_sign = in_dividend[DATA_W-1];
        b_sign = in_divisor[DATA_W-1];
      end
    endcase
    a_neg = sgn && a_sign;
    b_neg = sgn && b_sign;
    a_ext = (in_dividend & mask) | (a_neg ? ~mask : '0);
    b_ext = (in_divisor  & mask) | (b_neg ? ~mask : '0);
    a_mag = a_neg ? ('0 - a_ext) : a_ext;
    b_mag = b_neg ? ('0 - b_ext) : b_ext;
  end

  // restoring steps, one quotient bit per stage
  always_comb begin
    logic [DATA_W:0] trial;
    for (int k = 1; k <= STEPS; k++) begin
      trial = {stg_rem_r[k-1], stg_dvd_r[k-1][DATA_W-1]};
      if (trial >= {1'b0, stg_dvs_r[k-1]}) begin
        stg_rem_nxt[k] = data_t'(trial - {1'b0, stg_dvs_r[k-1]});
      end else begin
        stg_rem_nxt[k] = trial[DATA_W-1:0];
      end
      stg_dvd_nxt[k] = {stg_dvd_r[k-1][DATA_W-2:0], 1'b0};
    end
  end

  // sign restore; a zero divisor leaves the dividend magnitude in place
  assign res_nxt = stg_neg_r[STEPS] ? ('0 - stg_rem_r[STEPS]) : stg_rem_r[STEPS];

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= STEPS; k++) begin
        stg_vld_r[k] <= 1'b0;
      end
      res_vld_r <= 1'b0;
    end else if (adv) begin
      stg_vld_r[0] <= in_valid;
      for (int k = 1; k <= STEPS; k++) begin
        stg_vld_r[k] <= stg_vld_r[k-1];
      end
      res_vld_r <= stg_vld_r[STEPS];
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      stg_rem_r[0] <= '0;
      stg_dvd_r[0] <= a_mag;
      stg_dvs_r[0] <= b_mag;
      stg_neg_r[0] <= a_neg;
      stg_dz_r[0]  <= (b_ext == '0);
      for (int k = 1; k <= STEPS; k++) begin
        stg_rem_r[k] <= stg_rem_nxt[k];
        stg_dvd_r[k] <= stg_dvd_nxt[k];
        stg_dvs_r[k] <= stg_dvs_r[k-1];
        stg_neg_r[k] <= stg_neg_r[k-1];
        stg_dz_r[k]  <= stg_dz_r[k-1];
      end
      res_r    <= res_nxt;
      res_dz_r <= stg_dz_r[STEPS];
    end
  end

  // skid register catches the last stage when the output stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_ready) begin
        skid_vld_r <= 1'b0;
      end
    end else if (res_vld_r && !out_ready) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld_r && res_vld_r && !out_ready) begin
      skid_rem_r <= res_r;
      skid_dz_r  <= res_dz_r;
    end
  end

  // result channel, skid holds the older transaction
  assign out_valid          = skid_vld_r || res_vld_r;
  assign out_remainder      = skid_vld_r ? skid_rem_r : res_r;
  assign out_divide_by_zero = skid_vld_r ? skid_dz_r  : res_dz_r;

endmodule

`default_nettype wire

FILE: rtl/mwir_checker.sv
// ----------------------------------------------------------------------------
// mwir_checker
// Port-level checks of the multi-width integer remainder core.
// ----------------------------------------------------------------------------
`default_nettype none

module mwir_checker (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_wr_en,
  input  wire mwir_pkg::etype_t        cfg_wr_data,
  input  wire logic                    in_valid,
  input  wire logic                    in_ready,
  input  wire mwir_pkg::data_t         in_dividend,
  input  wire mwir_pkg::data_t         in_divisor,
  input  wire logic                    out_valid,
  input  wire logic                    out_ready,
  input  wire mwir_pkg::data_t         out_remainder,
  input  wire logic                    out_divide_by_zero
);

  import mwir_pkg::*;

  // shadow of the element type register
  etype_t etype_r;
  logic   unused_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      etype_r <= '0;
    end else if (cfg_wr_en) begin
      etype_r <= cfg_wr_data;
    end
  end

  assign unused_ok = ^{in_valid, in_dividend, in_divisor};

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_remainder) && $stable(out_divide_by_zero))
    else $error("stalled result changed");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input backpressure only follows a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  // upper result bits follow the element type extension
  a_extension: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((wid_t'(etype_r[1:0]) == WID_64) ||
       (!etype_r[ETYPE_SIGNED_BIT] && wid_t'(etype_r[1:0]) == WID_8 &&
        out_remainder[63:8] == '0) ||
       (!etype_r[ETYPE_SIGNED_BIT] && wid_t'(etype_r[1:0]) == WID_16 &&
        out_remainder[63:16] == '0) ||
       (!etype_r[ETYPE_SIGNED_BIT] && wid_t'(etype_r[1:0]) == WID_32 &&
        out_remainder[63:32] == '0) ||
       (etype_r[ETYPE_SIGNED_BIT] && wid_t'(etype_r[1:0]) == WID_8 &&
        (out_remainder[63:7] == '0 || out_remainder[63:7] == '1)) ||
       (etype_r[ETYPE_SIGNED_BIT] && wid_t'(etype_r[1:0]) == WID_16 &&
        (out_remainder[63:15] == '0 || out_remainder[63:15] == '1)) ||
       (etype_r[ETYPE_SIGNED_BIT] && wid_t'(etype_r[1:0]) == WID_32 &&
        (out_remainder[63:31] == '0 || out_remainder[63:31] == '1))))
    else $error("remainder not extended from element width");

endmodule

bind multi_width_integer_remainder_core mwir_checker u_mwir_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .cfg_wr_en          (cfg_wr_en),
  .cfg_wr_data        (cfg_wr_data),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_dividend        (in_dividend),
  .in_divisor         (in_divisor),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_remainder      (out_remainder),
  .out_divide_by_zero (out_divide_by_zero)
);

`default_nettype wire
